// File: rtl/assert_macros.svh
// Assertion macros shared by the translator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property on every rising edge, held off while reset is high.
`define I2P_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every rising edge, also during reset.
`define I2P_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define I2P_ASSERT(name, clk, rst, prop, msg)
`define I2P_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

// File: rtl/i2p_pkg.sv
// Types and constants of the infix to postfix translator.
`timescale 1ns / 1ps
package i2p_pkg;

  // Nesting depth of the parenthesis stack.
  localparam int MAX_DEPTH = 16;
  localparam int IDX_W = $clog2(MAX_DEPTH);
  localparam int LEVEL_W = $clog2(MAX_DEPTH + 1);

  // Depth of the command queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int TAG_W = 32;

  // Input token kinds.
  localparam logic [3:0] TK_OPERAND = 4'd0;
  localparam logic [3:0] TK_PLUS    = 4'd1;
  localparam logic [3:0] TK_MINUS   = 4'd2;
  localparam logic [3:0] TK_TIMES   = 4'd3;
  localparam logic [3:0] TK_DIVIDE  = 4'd4;
  localparam logic [3:0] TK_LPAREN  = 4'd5;
  localparam logic [3:0] TK_RPAREN  = 4'd6;
  localparam logic [3:0] TK_END     = 4'd7;
  localparam logic [3:0] TK_OTHER   = 4'd8;

  // Result kinds.
  typedef enum logic [2:0] {
    RK_OPERAND = 3'd0,
    RK_ADD     = 3'd1,
    RK_SUB     = 3'd2,
    RK_MUL     = 3'd3,
    RK_DIV     = 3'd4,
    RK_NEG     = 3'd5,
    RK_DONE    = 3'd6,
    RK_ERROR   = 3'd7
  } result_kind_t;

  // Parser position within the current level.
  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_FACTOR = 2'd1,
    PH_AFTER  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    MUL_NONE   = 2'd0,
    MUL_TIMES  = 2'd1,
    MUL_DIVIDE = 2'd2
  } mul_op_t;

  typedef enum logic [1:0] {
    ADD_NONE  = 2'd0,
    ADD_PLUS  = 2'd1,
    ADD_MINUS = 2'd2
  } add_op_t;

  // Pending operators of an enclosing level, saved on lparen.
  typedef struct packed {
    add_op_t add_op;
    mul_op_t mul_op;
    logic    negate;
  } saved_t;

  // One input beat.
  typedef struct packed {
    logic [3:0]       token_kind;
    logic [TAG_W-1:0] operand_tag;
  } token_t;

  // One output beat.
  typedef struct packed {
    result_kind_t     out_kind;
    logic [TAG_W-1:0] out_tag;
    logic             last_of_run;
  } result_t;

  // One queued command: the run of up to three results caused by a token.
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    result_kind_t     k0;
    result_kind_t     k1;
    result_kind_t     k2;
    logic [1:0]       last_idx;
  } cmd_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// File: rtl/i2p_queue.sv
// Command queue between the translator front and back.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module i2p_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  i2p_pkg::cmd_t          push_data,
  input  logic                   pop,
  output i2p_pkg::cmd_t          head,
  output i2p_pkg::queue_status_t status
);
  import i2p_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  // Entry storage; written only at the tail.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head         = entries[rd_ptr];
  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

  `I2P_ASSERT(a_count_bound, clk, rst, count <= QCNT_W'(QUEUE_DEPTH), "queue count overran")
  `I2P_ASSERT(a_no_push_full, clk, rst, status.full |-> !push, "push into a full queue")
  `I2P_ASSERT(a_no_pop_empty, clk, rst, status.empty |-> !pop, "pop from an empty queue")

endmodule

// File: rtl/i2p_front.sv
// Translator front: accepts tokens, runs the parser state and queues result runs.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module i2p_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   token_valid,
  output logic                   token_stall,
  input  i2p_pkg::token_t        token,
  input  i2p_pkg::queue_status_t q_status,
  output logic                   push,
  output i2p_pkg::cmd_t          push_data
);
  import i2p_pkg::*;

  phase_t             phase;
  phase_t             phase_next;
  logic               pending_negate;
  logic               pending_negate_next;
  mul_op_t            pending_mul_op;
  mul_op_t            pending_mul_op_next;
  add_op_t            pending_add_op;
  add_op_t            pending_add_op_next;
  logic [LEVEL_W-1:0] nest_level;
  logic [LEVEL_W-1:0] nest_level_next;
  logic [LEVEL_W-1:0] nest_dec;
  saved_t             stack [MAX_DEPTH];
  saved_t             restored;
  logic               stack_we;
  saved_t             stack_wdata;
  logic               accept;
  result_kind_t       emit_kind [3];
  logic [1:0]         emit_n;

  assign token_stall = q_status.full;
  assign accept      = token_valid && !token_stall;
  assign nest_dec    = nest_level - 1'b1;
  assign restored    = stack[nest_dec[IDX_W-1:0]];

  // Parser step: next state and the run of results for the current token.
  always_comb begin
    phase_next          = phase;
    pending_negate_next = pending_negate;
    pending_mul_op_next = pending_mul_op;
    pending_add_op_next = pending_add_op;
    nest_level_next     = nest_level;
    stack_we            = 1'b0;
    stack_wdata         = '{add_op: pending_add_op, mul_op: pending_mul_op,
                            negate: pending_negate};
    emit_kind[0]        = RK_OPERAND;
    emit_kind[1]        = RK_OPERAND;
    emit_kind[2]        = RK_OPERAND;
    emit_n              = 2'd0;

    case (phase)
      PH_START, PH_FACTOR: begin
        if (phase == PH_START && (token.token_kind inside {TK_PLUS, TK_MINUS})) begin
          // A leading sign; only minus leaves a mark.
          if (token.token_kind == TK_MINUS) begin
            pending_negate_next = 1'b1;
          end
          phase_next = PH_FACTOR;
        end else if (token.token_kind == TK_OPERAND) begin
          // Operand goes out at once, then the factor closes.
          emit_kind[emit_n] = RK_OPERAND;
          emit_n = emit_n + 2'd1;
          if (pending_mul_op == MUL_TIMES) begin
            emit_kind[emit_n] = RK_MUL;
            emit_n = emit_n + 2'd1;
          end else if (pending_mul_op == MUL_DIVIDE) begin
            emit_kind[emit_n] = RK_DIV;
            emit_n = emit_n + 2'd1;
          end
          pending_mul_op_next = MUL_NONE;
          phase_next          = PH_AFTER;
        end else if (token.token_kind == TK_LPAREN &&
                     nest_level != LEVEL_W'(MAX_DEPTH)) begin
          // Open a level: save this level's pending operators.
          stack_we            = 1'b1;
          nest_level_next     = nest_level + 1'b1;
          pending_negate_next = 1'b0;
          pending_mul_op_next = MUL_NONE;
          pending_add_op_next = ADD_NONE;
          phase_next          = PH_START;
        end else begin
          emit_kind[0]        = RK_ERROR;
          emit_n              = 2'd1;
          phase_next          = PH_START;
          pending_negate_next = 1'b0;
          pending_mul_op_next = MUL_NONE;
          pending_add_op_next = ADD_NONE;
          nest_level_next     = '0;
        end
      end
      PH_AFTER: begin
        if (token.token_kind inside {TK_TIMES, TK_DIVIDE}) begin
          pending_mul_op_next = (token.token_kind == TK_TIMES) ? MUL_TIMES : MUL_DIVIDE;
          phase_next          = PH_FACTOR;
        end else if ((token.token_kind inside {TK_PLUS, TK_MINUS}) ||
                     (token.token_kind == TK_RPAREN && nest_level != '0) ||
                     (token.token_kind == TK_END && nest_level == '0)) begin
          // The current term closes: negate first, then the additive operator.
          if (pending_negate) begin
            emit_kind[emit_n] = RK_NEG;
            emit_n = emit_n + 2'd1;
          end
          if (pending_add_op == ADD_PLUS) begin
            emit_kind[emit_n] = RK_ADD;
            emit_n = emit_n + 2'd1;
          end else if (pending_add_op == ADD_MINUS) begin
            emit_kind[emit_n] = RK_SUB;
            emit_n = emit_n + 2'd1;
          end
          pending_negate_next = 1'b0;
          pending_add_op_next = ADD_NONE;
          if (token.token_kind inside {TK_PLUS, TK_MINUS}) begin
            pending_add_op_next = (token.token_kind == TK_PLUS) ? ADD_PLUS : ADD_MINUS;
            phase_next          = PH_FACTOR;
          end else if (token.token_kind == TK_RPAREN) begin
            // Close a level: restore its parent and close the parent's factor.
            nest_level_next     = nest_dec;
            pending_negate_next = restored.negate;
            pending_add_op_next = restored.add_op;
            if (restored.mul_op == MUL_TIMES) begin
              emit_kind[emit_n] = RK_MUL;
              emit_n = emit_n + 2'd1;
            end else if (restored.mul_op == MUL_DIVIDE) begin
              emit_kind[emit_n] = RK_DIV;
              emit_n = emit_n + 2'd1;
            end
            pending_mul_op_next = MUL_NONE;
            phase_next          = PH_AFTER;
          end else begin
            // End of the whole expression.
            emit_kind[emit_n] = RK_DONE;
            emit_n = emit_n + 2'd1;
            phase_next          = PH_START;
            pending_mul_op_next = MUL_NONE;
            nest_level_next     = '0;
          end
        end else begin
          emit_kind[0]        = RK_ERROR;
          emit_n              = 2'd1;
          phase_next          = PH_START;
          pending_negate_next = 1'b0;
          pending_mul_op_next = MUL_NONE;
          pending_add_op_next = ADD_NONE;
          nest_level_next     = '0;
        end
      end
      default: begin
        emit_kind[0]        = RK_ERROR;
        emit_n              = 2'd1;
        phase_next          = PH_START;
        pending_negate_next = 1'b0;
        pending_mul_op_next = MUL_NONE;
        pending_add_op_next = ADD_NONE;
        nest_level_next     = '0;
      end
    endcase
  end

  // Queue the run; tokens that only record an operator queue nothing.
  assign push               = accept && (emit_n != 2'd0);
  assign push_data.tag      = token.operand_tag;
  assign push_data.k0       = emit_kind[0];
  assign push_data.k1       = emit_kind[1];
  assign push_data.k2       = emit_kind[2];
  assign push_data.last_idx = emit_n - 2'd1;

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_START;
      pending_negate <= 1'b0;
      pending_mul_op <= MUL_NONE;
      pending_add_op <= ADD_NONE;
      nest_level     <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      pending_negate <= pending_negate_next;
      pending_mul_op <= pending_mul_op_next;
      pending_add_op <= pending_add_op_next;
      nest_level     <= nest_level_next;
    end
  end

  // Level stack; an entry is read only after its lparen wrote it.
  always_ff @(posedge clk) begin
    if (accept && stack_we) begin
      stack[nest_level[IDX_W-1:0]] <= stack_wdata;
    end
  end

  `I2P_ASSERT(a_nest_bound, clk, rst, nest_level <= LEVEL_W'(MAX_DEPTH), "nesting beyond stack depth")
  `I2P_ASSERT(a_other_is_error, clk, rst, (accept && token.token_kind == TK_OTHER) |-> (push && push_data.k0 == RK_ERROR && push_data.last_idx == 2'd0), "unknown token did not give a lone error")
  `I2P_ASSERT(a_lparen_push, clk, rst, (accept && phase != PH_AFTER && token.token_kind == TK_LPAREN && nest_level != LEVEL_W'(MAX_DEPTH)) |=> (nest_level == $past(nest_level) + 1'b1), "lparen did not open a level")
  `I2P_ASSERT(a_mulop_silent, clk, rst, (accept && phase == PH_AFTER && token.token_kind == TK_TIMES) |-> !push, "multiplicative operator released a result early")

endmodule

// File: rtl/i2p_back.sv
// Translator back: expands queued runs into result beats behind an output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module i2p_back (
  input  logic                   clk,
  input  logic                   rst,
  input  i2p_pkg::cmd_t          head,
  input  i2p_pkg::queue_status_t q_status,
  output logic                   pop,
  output logic                   result_valid,
  input  logic                   result_stall,
  output i2p_pkg::result_t       result
);
  import i2p_pkg::*;

  logic [1:0]   idx;
  logic         load;
  logic         at_last;
  result_kind_t cur_kind;

  // Output register is free when empty or being taken this cycle.
  assign load    = !q_status.empty && (!result_valid || !result_stall);
  assign at_last = (idx == head.last_idx);
  assign pop     = load && at_last;

  // Pick the result of the run at the current position.
  always_comb begin
    case (idx)
      2'd0:    cur_kind = head.k0;
      2'd1:    cur_kind = head.k1;
      default: cur_kind = head.k2;
    endcase
  end

  // Position within the run and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
        idx          <= at_last ? 2'd0 : idx + 2'd1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      result.out_kind    <= cur_kind;
      result.out_tag     <= (cur_kind == RK_OPERAND) ? head.tag : '0;
      result.last_of_run <= at_last;
    end
  end

  `I2P_ASSERT(a_tag_zero, clk, rst, (result_valid && result.out_kind != RK_OPERAND) |-> (result.out_tag == '0), "nonzero tag on an operator result")
  `I2P_ASSERT(a_done_last, clk, rst, (result_valid && (result.out_kind == RK_DONE || result.out_kind == RK_ERROR)) |-> result.last_of_run, "done or error not at the end of its run")
  `I2P_ASSERT(a_idx_bound, clk, rst, !q_status.empty |-> (idx <= head.last_idx), "run position past the end of the run")

endmodule

// File: rtl/infix_to_postfix_translator_unit.sv
// Top level of the infix to postfix translator.
`timescale 1ns / 1ps
// Takes one expression token per beat and gives the postfix form as result beats,
// one to three per token, the last of each run marked by last_of_run; tokens that
// only record an operator give none. A token is taken in every cycle while the
// four-entry command queue between the parser front and the result back has room;
// the back drains one result beat per cycle while result_stall is low, and the results
// of a token pass through the command queue and then the output register. An error
// result resets the parser; parentheses nest up to sixteen deep. There is no clearing
// pass after reset.
module infix_to_postfix_translator_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             token_valid,
  output logic             token_stall,
  input  i2p_pkg::token_t  token,
  output logic             result_valid,
  input  logic             result_stall,
  output i2p_pkg::result_t result
);
  import i2p_pkg::*;

  queue_status_t q_status;
  logic          push;
  cmd_t          push_data;
  logic          pop;
  cmd_t          head;

  i2p_front u_front (
    .clk         (clk),
    .rst         (rst),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token       (token),
    .q_status    (q_status),
    .push        (push),
    .push_data   (push_data)
  );

  i2p_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  i2p_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_status     (q_status),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
